// ----- rtl/cbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper with IRQ counter.
// No dependencies; imported by cbm_mod_unit, the top level and the testbench.
package cbm_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRG,
    S_CHR,
    S_DONE
  } state_t;

  localparam logic [1:0]  CFG_PRG_UNITS = 2'd0;
  localparam logic [1:0]  CFG_CHR_UNITS = 2'd1;

  localparam logic [15:0] HI_BANK_BASE  = 16'hE000;
  localparam logic [15:0] IRQ_CTRL_BASE = 16'h8000;
  localparam logic [15:0] IRQ_CTRL_BIT  = 16'h2000;
  localparam logic [15:0] COUNT_MASK    = 16'h7FFF;

  localparam logic [6:0]  PRG_UNITS_RESET = 7'd2;
  localparam logic [4:0]  CHR_UNITS_RESET = 5'd0;

  localparam int DIVIDEND_W = 4;
  localparam int DIVISOR_W  = 8;

endpackage

// ----- rtl/cbm_mod_unit.sv -----
// Iterative restoring modulo unit: one compare-and-subtract per cycle.
// Depends on cbm_pkg for operand widths.
module cbm_mod_unit
  import cbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                 done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                          active;
  logic [STEP_W-1:0]             step;
  logic [DIVIDEND_W-1:0]         quot;
  logic [DIVISOR_W-1:0]          div;
  logic [DIVISOR_W:0]            trial;
  logic [DIVISOR_W-1:0]          rem_next;

  always_comb begin
    trial = {remainder, quot[DIVIDEND_W-1]};
    if (trial >= {1'b0, div}) begin
      rem_next = DIVISOR_W'(trial - {1'b0, div});
    end else begin
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= !start && active && step == '0;
      if (start) begin
        active <= 1'b1;
      end else if (active && step == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step      <= STEP_W'(DIVIDEND_W - 1);
      quot      <= dividend;
      div       <= divisor;
      remainder <= '0;
    end else if (active) begin
      step      <= step - 1'b1;
      quot      <= {quot[DIVIDEND_W-2:0], 1'b0};
      remainder <= rem_next;
    end
  end

endmodule

// ----- rtl/cartridge_bank_mapper_irq_unit.sv -----
// Cartridge bank mapper with cycle-counting IRQ timer, top level.
// Depends on cbm_pkg and cbm_mod_unit.
//
// Input stream (s_*): one transfer is a CPU write (s_tuser = 0) or a clock
// advance (s_tuser = 1). Bank selects, IRQ enable and the cycle counter are
// updated at the input transfer. Output stream (m_*): exactly one transfer
// per input transfer with the current bank map and the IRQ raise/ack flags.
// Configuration (cfg_*): ROM sizes, written while the block is idle; always
// ready, unknown indexes ignored.
// Order of work: after an input transfer, the PRG and CHR bank modulos
// each take 4 steps plus a done flag in the shared compare-subtract unit,
// then the output register loads. A new item is taken the cycle after
// the output register loads, so an item is only taken once the previous
// result has left the modulo unit.
// A stalled receiver holds the result in the output register; one more item
// is processed and waits in S_DONE until the register frees up.
// Reset (rst, synchronous): ROM sizes return to 2 x 16KB PRG and no CHR,
// bank selects, IRQ enable and counter clear, output stream empties.
module cartridge_bank_mapper_irq_unit
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // address[15:0], write_data[23:16], cycles[39:24]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // bank_6000[7:0], bank_8000[15:8], bank_a000[23:16],
                                 // bank_c000[31:24], chr_bank_out[35:32],
                                 // irq_raise[36], irq_ack[37], zero[39:38]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  state_t      state, state_next;
  logic [6:0]  prg_units;
  logic [4:0]  chr_units;
  logic [3:0]  chr_select, chr_select_next;
  logic [3:0]  prg_select, prg_select_next;
  logic        irq_on, irq_on_next;
  logic [15:0] cycle_count, cycle_count_next;
  logic        raise, raise_next;
  logic        ack, ack_next;
  logic [3:0]  prg_rem;
  logic [3:0]  chr_rem;

  logic        in_xfer;
  logic        load_out;
  logic        div_start;
  logic        div_done;
  logic [3:0]  div_dividend;
  logic [7:0]  div_divisor;
  logic [7:0]  div_rem;

  logic [15:0] address;
  logic [7:0]  write_data;
  logic [15:0] cycles;
  logic [15:0] sum;
  logic [7:0]  prg_count;
  logic [7:0]  chr_count;
  logic [7:0]  last_bank;

  assign address    = s_tdata[15:0];
  assign write_data = s_tdata[23:16];
  assign cycles     = s_tdata[39:24];
  assign in_xfer    = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;

  assign prg_count = {prg_units, 1'b0};
  assign chr_count = (chr_units == '0) ? 8'd1 : {3'b000, chr_units};
  assign last_bank = prg_count - 8'd1;

  // Item effect on mapper state
  always_comb begin
    chr_select_next  = chr_select;
    prg_select_next  = prg_select;
    irq_on_next      = irq_on;
    cycle_count_next = cycle_count;
    raise_next       = 1'b0;
    ack_next         = 1'b0;
    sum              = cycle_count + cycles;
    if (!s_tuser) begin
      if (address >= HI_BANK_BASE) begin
        chr_select_next = write_data[3:0];
        prg_select_next = write_data[7:4];
      end else if (address >= IRQ_CTRL_BASE && (address & IRQ_CTRL_BIT) != '0) begin
        if (write_data[0]) begin
          irq_on_next      = 1'b1;
          cycle_count_next = '0;
        end else begin
          irq_on_next = 1'b0;
          ack_next    = 1'b1;
        end
      end
    end else if (irq_on) begin
      if (sum[15]) begin
        cycle_count_next = sum & COUNT_MASK;
        raise_next       = 1'b1;
      end else begin
        cycle_count_next = sum;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    div_dividend = chr_select;
    div_divisor  = chr_count;
    case (state)
      S_IDLE: begin
        s_tready     = 1'b1;
        div_dividend = prg_select_next;
        div_divisor  = prg_count;
        if (s_tvalid) begin
          div_start  = 1'b1;
          state_next = S_PRG;
        end
      end
      S_PRG: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_CHR;
        end
      end
      S_CHR: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  cbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      prg_units   <= PRG_UNITS_RESET;
      chr_units   <= CHR_UNITS_RESET;
      chr_select  <= '0;
      prg_select  <= '0;
      irq_on      <= 1'b0;
      cycle_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRG_UNITS) begin
          prg_units <= cfg_data;
        end else if (cfg_index == CFG_CHR_UNITS) begin
          chr_units <= cfg_data[4:0];
        end
      end
      if (in_xfer) begin
        chr_select  <= chr_select_next;
        prg_select  <= prg_select_next;
        irq_on      <= irq_on_next;
        cycle_count <= cycle_count_next;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      raise <= raise_next;
      ack   <= ack_next;
    end
    if (state == S_PRG && div_done) begin
      prg_rem <= (prg_count == '0) ? 4'd0 : div_rem[3:0];
    end
    if (state == S_CHR && div_done) begin
      chr_rem <= div_rem[3:0];
    end
    if (load_out) begin
      m_tdata[7:0]   <= {4'b0000, prg_rem};
      m_tdata[15:8]  <= last_bank - 8'd3;
      m_tdata[23:16] <= (prg_count >= 8'd2) ? prg_count - 8'd2 : 8'd0;
      m_tdata[31:24] <= last_bank;
      m_tdata[35:32] <= chr_rem;
      m_tdata[36]    <= raise;
      m_tdata[37]    <= ack;
      m_tdata[39:38] <= 2'b00;
    end
  end

endmodule

// ----- rtl/cbm_checker.sv -----
// Port-level checks for the cartridge bank mapper, bound to the top level.
// Depends only on the top level's ports.
module cbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[36] && m_tdata[37]))
    else $error("raise and ack in one transfer");

  a_slots: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:24] == 8'(m_tdata[15:8] + 8'd3))
    else $error("PRG slot map inconsistent");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind cartridge_bank_mapper_irq_unit cbm_checker u_cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/cartridge_bank_mapper_irq_unit_tb.sv -----
// Self-checking testbench for cartridge_bank_mapper_irq_unit: directed table, then random
// CPU writes and clock advances over several ROM size settings, with bursty input and stalls.
// Depends on cbm_pkg and the block RTL; results are checked by a local model or pinned rows.
module cartridge_bank_mapper_irq_unit_tb;
  import cbm_pkg::*;

  localparam logic       MODE_WRITE      = 1'b0;
  localparam logic       MODE_CLOCK      = 1'b1;
  localparam logic [1:0] CFG_UNUSED_A    = 2'd2;
  localparam logic [1:0] CFG_UNUSED_B    = 2'd3;
  localparam int         NUM_PHASES      = 8;
  localparam int         ITEMS_PER_PHASE = 185;
  localparam int         PRESS_PHASE     = 2;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         DRAIN_CYCLES    = 16;
  localparam int         NUM_ROWS        = 24;

  typedef struct packed {
    logic [1:0] pad;
    logic       irq_ack;
    logic       irq_raise;
    logic [3:0] chr_bank_out;
    logic [7:0] bank_c000;
    logic [7:0] bank_a000;
    logic [7:0] bank_8000;
    logic [7:0] bank_6000;
  } map_result_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] cycles;
  } bus_item_t;

  typedef struct packed {
    bus_item_t   item;
    logic        pinned;
    map_result_t want;
  } row_t;

  typedef struct packed {
    logic        pinned;
    map_result_t want;
  } pinned_t;

  // Map seen right after reset: 2 x 16KB PRG (four 8KB banks), no CHR
  function automatic map_result_t rst_map(input logic [7:0] b6, input logic raise,
                                          input logic ack);
    map_result_t r;
    r = '0;
    r.bank_6000 = b6;
    r.bank_8000 = 8'd0;
    r.bank_a000 = 8'd2;
    r.bank_c000 = 8'd3;
    r.irq_raise = raise;
    r.irq_ack   = ack;
    return r;
  endfunction

  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'hFFFF}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hFFFF, 8'hFF, 16'h0000}, 1'b1, rst_map(8'd3, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hE000, 8'h00, 16'hFFFF}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hDFFF, 8'hFF, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hA000, 8'h00, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b1)},
    '{'{MODE_WRITE, 16'h9FFF, 8'h01, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'h7FFF, 8'h00, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'h0000, 8'h00, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hBFFF, 8'h01, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h7FFF}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h0001}, 1'b1, rst_map(8'd0, 1'b1, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h8000}, 1'b1, rst_map(8'd0, 1'b1, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h7FFF}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'hFFFF}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hA001, 8'hFE, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b1)},
    '{'{MODE_CLOCK, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hBFFE, 8'hFF, 16'h0000}, 1'b1, rst_map(8'd0, 1'b0, 1'b0)},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h8001}, 1'b1, rst_map(8'd0, 1'b1, 1'b0)},
    '{'{MODE_WRITE, 16'hE5A5, 8'h5A, 16'h0000}, 1'b1, rst_map(8'd1, 1'b0, 1'b0)},
    '{'{MODE_WRITE, 16'hE000, 8'hA5, 16'h0000}, 1'b0, '0},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'h5555}, 1'b0, '0},
    '{'{MODE_CLOCK, 16'h0000, 8'h00, 16'hAAAA}, 1'b0, '0},
    '{'{MODE_WRITE, 16'hA000, 8'h00, 16'h0000}, 1'b0, '0}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;   // address[15:0], write_data[23:16], cycles[39:24]
  logic        s_tuser   = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;          // bank_6000, bank_8000, bank_a000, bank_c000, chr, raise, ack
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data  = '0;

  cartridge_bank_mapper_irq_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local model of the mapper
  logic [6:0]  rom_prg_units;
  logic [4:0]  rom_chr_units;
  logic [3:0]  sel_chr;
  logic [3:0]  sel_prg;
  logic        timer_on;
  logic [15:0] timer_count;

  map_result_t map_expect_q[$];
  pinned_t     pinned_q[$];

  int n_sent    = 0;
  int n_checked = 0;
  int n_raise   = 0;
  int n_ack     = 0;
  int n_err     = 0;
  bit press_on  = 1'b0;
  bit gaps_on   = 1'b1;
  int burst_left = 0;

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still pending", $time, map_expect_q.size());
    $display("cartridge_bank_mapper_irq_unit_tb NOT OK");
    $finish;
  end

  function automatic map_result_t predict_map(input bus_item_t it);
    map_result_t r;
    logic [7:0]  cnt;
    logic [7:0]  last;
    logic [4:0]  chr_n;
    r = '0;
    if (it.mode == MODE_WRITE) begin
      if (it.addr >= HI_BANK_BASE) begin
        sel_chr = it.data[3:0];
        sel_prg = it.data[7:4];
      end else if (it.addr >= IRQ_CTRL_BASE && (it.addr & IRQ_CTRL_BIT) != 16'd0) begin
        if (it.data[0]) begin
          timer_on    = 1'b1;
          timer_count = '0;
        end else begin
          timer_on  = 1'b0;
          r.irq_ack = 1'b1;
        end
      end
    end else if (timer_on) begin
      timer_count = timer_count + it.cycles;
      if (timer_count[15]) begin
        timer_count = timer_count & COUNT_MASK;
        r.irq_raise = 1'b1;
      end
    end
    cnt   = {rom_prg_units, 1'b0};
    last  = cnt - 8'd1;
    chr_n = (rom_chr_units == 5'd0) ? 5'd1 : rom_chr_units;
    r.bank_6000    = (cnt != 8'd0) ? ({4'd0, sel_prg} % cnt) : 8'd0;
    r.bank_8000    = last - 8'd3;
    r.bank_a000    = (cnt >= 8'd2) ? cnt - 8'd2 : 8'd0;
    r.bank_c000    = last;
    r.chr_bank_out = 4'({1'b0, sel_chr} % chr_n);
    return r;
  endfunction

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    bus_item_t   it;
    map_result_t want;
    map_result_t got;
    pinned_t     p;
    if (rst) begin
      rom_prg_units = PRG_UNITS_RESET;
      rom_chr_units = CHR_UNITS_RESET;
      sel_chr       = '0;
      sel_prg       = '0;
      timer_on      = 1'b0;
      timer_count   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRG_UNITS: rom_prg_units = cfg_data;
          CFG_CHR_UNITS: rom_chr_units = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        it   = '{s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[39:24]};
        want = predict_map(it);
        p    = pinned_q.pop_front();
        if (p.pinned)
          want = p.want;
        n_raise += want.irq_raise;
        n_ack   += want.irq_ack;
        map_expect_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = map_result_t'(m_tdata);
        if (map_expect_q.size() == 0) begin
          n_err++;
          $display("%0t: result with nothing expected, expected none, actual %h", $time, m_tdata);
        end else begin
          want = map_expect_q.pop_front();
          n_checked++;
          cmp_field("bank_6000", want.bank_6000, got.bank_6000);
          cmp_field("bank_8000", want.bank_8000, got.bank_8000);
          cmp_field("bank_a000", want.bank_a000, got.bank_a000);
          cmp_field("bank_c000", want.bank_c000, got.bank_c000);
          cmp_field("chr_bank_out", want.chr_bank_out, got.chr_bank_out);
          cmp_field("irq_raise", want.irq_raise, got.irq_raise);
          cmp_field("irq_ack", want.irq_ack, got.irq_ack);
          cmp_field("pad", want.pad, got.pad);
        end
      end
    end
  end

  // Receiver: runs of free flow, light and heavy stalls, plus one long hold-off
  initial begin : rx_pattern
    int  style;
    int  run_len;
    bit  held;
    held = 1'b0;
    forever begin
      if (press_on && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      style   = $urandom_range(0, 2);
      run_len = $urandom_range(20, 200);
      repeat (run_len) begin
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer(input bus_item_t it, input logic pinned, input map_result_t want);
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {it.cycles, it.data, it.addr};
    pinned_q.push_back('{pinned, want});
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (map_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic bus_item_t rand_item();
    bus_item_t it;
    int        pick;
    it.mode   = MODE_WRITE;
    it.addr   = 16'($urandom);
    it.data   = 8'($urandom);
    it.cycles = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.mode = MODE_CLOCK;
      case ($urandom_range(0, 3))
        0: it.cycles = 16'($urandom_range(0, 255));
        1: it.cycles = 16'($urandom_range(0, 16'h1FFF));
        2: it.cycles = 16'h7FFF + 16'($urandom_range(0, 2));
        default: ;
      endcase
    end else if (pick < 55) begin
      it.addr = HI_BANK_BASE | 16'($urandom_range(0, 16'h1FFF));
    end else if (pick < 75) begin
      it.addr    = IRQ_CTRL_BASE | IRQ_CTRL_BIT | 16'($urandom_range(0, 16'h1FFF));
      it.data[0] = ($urandom_range(0, 3) != 0);
    end
    return it;
  endfunction

  initial begin : run
    logic [6:0] prg_val;
    logic [6:0] chr_val;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1:       begin prg_val = 7'h7F; chr_val = 7'h1F; end
          2:       begin prg_val = 7'h01; chr_val = 7'h01; end
          3:       begin prg_val = 7'h00; chr_val = 7'h10; end
          4:       begin prg_val = 7'h40; chr_val = 7'h0F; end
          5:       begin prg_val = 7'h03; chr_val = 7'h65; end
          default: begin
            prg_val = 7'($urandom_range(0, 127));
            chr_val = 7'($urandom_range(0, 127));
          end
        endcase
        cfg_write(CFG_PRG_UNITS, prg_val);
        cfg_write(CFG_CHR_UNITS, chr_val);
        cfg_write((ph % 2 == 0) ? CFG_UNUSED_A : CFG_UNUSED_B, 7'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      gaps_on = (ph != PRESS_PHASE) && (ph != 5);
      if (ph == PRESS_PHASE)
        press_on = 1'b1;
      if (ph == 0) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          offer(DIR_ROWS[i].item, DIR_ROWS[i].pinned, DIR_ROWS[i].want);
          pace();
        end
      end
      repeat (ITEMS_PER_PHASE) begin
        offer(rand_item(), 1'b0, '0);
        pace();
      end
    end
    drain();
    $display("%0d transfers over %0d ROM size settings, %0d results checked", n_sent,
             NUM_PHASES, n_checked);
    $display("timer raised %0d times and was acknowledged %0d times", n_raise, n_ack);
    if (n_err == 0 && map_expect_q.size() == 0) begin
      $display("cartridge_bank_mapper_irq_unit_tb OK");
    end else begin
      $display("cartridge_bank_mapper_irq_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
